/* rtl/scc_pkg.sv */
// Package for the sparse column count summary core.
// Widths, register indexes and payload types; no dependencies.
`default_nettype none

package scc_pkg;

    localparam int GENE_BITS  = 16;
    localparam int GENE_COUNT = 1 << GENE_BITS;
    localparam int COUNT_BITS = 24;
    localparam int SUM_BITS   = 40;
    localparam int TALLY_BITS = 17;
    localparam int FRAC_BITS  = 16;
    localparam int QUO_BITS   = FRAC_BITS + 1;
    localparam int STEP_BITS  = $clog2(QUO_BITS);

    localparam int CFG_IDX_BITS  = 8;
    localparam int CFG_DATA_BITS = 1;

    typedef logic [1:0]              t_mode;
    typedef logic [GENE_BITS-1:0]    t_gene;
    typedef logic [COUNT_BITS-1:0]   t_count;
    typedef logic [SUM_BITS-1:0]     t_sum;
    typedef logic [TALLY_BITS-1:0]   t_tally;
    typedef logic [FRAC_BITS-1:0]    t_frac;
    typedef logic [CFG_IDX_BITS-1:0] t_cfg_idx;
    typedef logic [CFG_DATA_BITS-1:0] t_cfg_data;

    // Input item modes
    localparam t_mode MODE_SET_FLAG = 2'd0;
    localparam t_mode MODE_ENTRY    = 2'd1;
    localparam t_mode MODE_CLOSE    = 2'd2;

    // Configuration register indexes
    localparam t_cfg_idx REG_MITO_ENABLE = 8'd0;
    localparam t_cfg_idx REG_MAX_ENABLE  = 8'd1;

    localparam t_sum   SUM_MAX   = '1;
    localparam t_tally TALLY_MAX = '1;
    localparam t_frac  FRAC_MAX  = '1;

endpackage

`default_nettype wire

/* rtl/scc_if.sv */
// Valid/ready channel interfaces for the sparse column count summary core.
// Depends on scc_pkg for payload types.
`default_nettype none

interface scc_in_if;
    import scc_pkg::*;
    logic   valid;
    logic   ready;
    t_mode  mode;
    t_gene  gene_index;
    t_count count_value;
    modport source (output valid, mode, gene_index, count_value, input ready);
    modport sink   (input valid, mode, gene_index, count_value, output ready);
endinterface

interface scc_out_if;
    import scc_pkg::*;
    logic   valid;
    logic   ready;
    t_sum   total_count;
    t_tally nonzero_genes;
    t_frac  mito_fraction;
    t_gene  top_gene;
    t_frac  top_fraction;
    logic   zero_total;
    modport source (output valid, total_count, nonzero_genes, mito_fraction,
                    top_gene, top_fraction, zero_total, input ready);
    modport sink   (input valid, total_count, nonzero_genes, mito_fraction,
                    top_gene, top_fraction, zero_total, output ready);
endinterface

interface scc_cfg_if;
    import scc_pkg::*;
    logic      valid;
    logic      ready;
    t_cfg_idx  index;
    t_cfg_data data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* rtl/sparse_column_count_summary_core.sv */
// Sparse column count summary core: flag memory, running sums, shared divider.
// Depends on scc_pkg and the channel interfaces in scc_if.sv.
//
//  channel  | dir | transaction
//  i_in     | in  | mode, gene_index, count_value
//  o_out    | out | total_count, nonzero_genes, mito_fraction, top_gene,
//           |     | top_fraction, zero_total
//  i_cfg    | in  | index, data (always ready)
//
// Flag item: written to the flag memory on acceptance. Entry: flag memory read,
// then accumulate. Close: 2 x 17 steps of one shared 41-bit compare/subtract,
// then the output register is loaded; it waits there while a prior result is
// untaken. After reset a clearing pass zeroes all GENE_COUNT (65536) flag memory
// entries; i_in is not ready meanwhile. Inputs are taken while a result waits.
`default_nettype none

module sparse_column_count_summary_core (
    input  wire         i_clk,
    input  wire         i_rst_n,
    scc_in_if.sink      i_in,
    scc_out_if.source   o_out,
    scc_cfg_if.sink     i_cfg
);
    import scc_pkg::*;

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_ACC   = 3'd2;
    localparam logic [2:0] ST_DIV   = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    logic [2:0] r_state, n_state;

    // Flag memory
    logic r_flag_mem [GENE_COUNT];
    logic r_flag_rd;
    logic w_we;
    t_gene w_waddr;
    logic w_wdata;
    t_gene r_clr_addr;

    // Config
    logic r_mito_en, r_max_en;

    // Captured entry
    t_gene  r_gene;
    t_count r_count;

    // Column state
    t_sum   r_count_sum, r_mito_sum;
    t_tally r_tally;
    t_count r_best_count;
    t_gene  r_best_gene;

    // Divider
    logic [SUM_BITS:0]   r_rem;
    logic [QUO_BITS-1:0] r_quo;
    logic [STEP_BITS-1:0] r_step;
    logic                r_phase;
    t_frac               r_mito_frac, r_top_frac;

    // Output register
    logic   r_out_valid;
    t_sum   r_o_total;
    t_tally r_o_tally;
    t_frac  r_o_mito, r_o_top_frac;
    t_gene  r_o_top_gene;
    logic   r_o_zero;

    logic in_acc, cfg_acc, out_free;
    assign in_acc   = i_in.valid && i_in.ready;
    assign cfg_acc  = i_cfg.valid && i_cfg.ready;
    assign out_free = !r_out_valid || o_out.ready;

    assign i_in.ready  = (r_state == ST_IDLE);
    assign i_cfg.ready = 1'b1;

    assign o_out.valid         = r_out_valid;
    assign o_out.total_count   = r_o_total;
    assign o_out.nonzero_genes = r_o_tally;
    assign o_out.mito_fraction = r_o_mito;
    assign o_out.top_gene      = r_o_top_gene;
    assign o_out.top_fraction  = r_o_top_frac;
    assign o_out.zero_total    = r_o_zero;

    // ---------------- flag memory ----------------
    always_comb begin
        if (r_state == ST_CLEAR) begin
            w_we    = 1'b1;
            w_waddr = r_clr_addr;
            w_wdata = 1'b0;
        end else begin
            w_we    = in_acc && (i_in.mode == MODE_SET_FLAG);
            w_waddr = i_in.gene_index;
            w_wdata = i_in.count_value[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_flag_mem[w_waddr] <= w_wdata;
        end
        r_flag_rd <= r_flag_mem[i_in.gene_index];
    end

    // ---------------- accumulate datapath ----------------
    t_sum            w_c_ext;
    logic [SUM_BITS:0] w_cnt_add, w_mito_add;
    logic            w_better;
    always_comb begin
        w_c_ext    = {{(SUM_BITS-COUNT_BITS){1'b0}}, r_count};
        w_cnt_add  = {1'b0, r_count_sum} + {1'b0, w_c_ext};
        w_mito_add = {1'b0, r_mito_sum} + {1'b0, w_c_ext};
        w_better   = (r_count > r_best_count) ||
                     ((r_count == r_best_count) && (r_count != '0) &&
                      (r_gene < r_best_gene));
    end

    // ---------------- shared divider step ----------------
    logic [SUM_BITS:0]   w_trial;
    logic [SUM_BITS+1:0] w_diff;
    logic                w_ge;
    logic [QUO_BITS-1:0] w_quo_next;
    t_frac               w_frac;
    logic                w_last;
    always_comb begin
        // remainder stays below the divisor, so the shift never overflows
        w_trial    = (r_step == '0) ? r_rem : {r_rem[SUM_BITS-1:0], 1'b0};
        w_diff     = {1'b0, w_trial} - {2'b00, r_count_sum};
        w_ge       = !w_diff[SUM_BITS+1];
        w_quo_next = {r_quo[QUO_BITS-2:0], w_ge};
        w_frac     = w_quo_next[QUO_BITS-1] ? FRAC_MAX : w_quo_next[FRAC_BITS-1:0];
        w_last     = (r_step == STEP_BITS'(QUO_BITS - 1));
    end

    // ---------------- sequencer ----------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: if (r_clr_addr == t_gene'(GENE_COUNT - 1)) n_state = ST_IDLE;
            ST_IDLE: begin
                if (in_acc && i_in.mode == MODE_ENTRY) n_state = ST_ACC;
                else if (in_acc && i_in.mode == MODE_CLOSE) n_state = ST_DIV;
            end
            ST_ACC:  n_state = ST_IDLE;
            ST_DIV:  if (w_last && r_phase) n_state = ST_DONE;
            ST_DONE: if (out_free) n_state = ST_IDLE;
            default: n_state = ST_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_CLEAR;
            r_clr_addr   <= '0;
            r_mito_en    <= 1'b1;
            r_max_en     <= 1'b1;
            r_out_valid  <= 1'b0;
            r_count_sum  <= '0;
            r_mito_sum   <= '0;
            r_tally      <= '0;
            r_best_count <= '0;
            r_best_gene  <= '0;
        end else begin
            r_state <= n_state;

            if (cfg_acc) begin
                if (i_cfg.index == REG_MITO_ENABLE) r_mito_en <= i_cfg.data[0];
                if (i_cfg.index == REG_MAX_ENABLE)  r_max_en  <= i_cfg.data[0];
            end

            if (r_state == ST_CLEAR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end

            if (r_state == ST_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end

            if (r_state == ST_ACC) begin
                r_count_sum <= w_cnt_add[SUM_BITS] ? SUM_MAX : w_cnt_add[SUM_BITS-1:0];
                if (r_flag_rd) begin
                    r_mito_sum <= w_mito_add[SUM_BITS] ? SUM_MAX
                                                       : w_mito_add[SUM_BITS-1:0];
                end
                if (r_count != '0 && r_tally != TALLY_MAX) begin
                    r_tally <= r_tally + 1'b1;
                end
                if (w_better) begin
                    r_best_count <= r_count;
                    r_best_gene  <= r_gene;
                end
            end

            if (r_state == ST_DONE && out_free) begin
                r_count_sum  <= '0;
                r_mito_sum   <= '0;
                r_tally      <= '0;
                r_best_count <= '0;
                r_best_gene  <= '0;
            end
        end
    end

    // Payload registers, no reset
    logic w_zero;
    assign w_zero = (r_count_sum == '0);

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_gene  <= i_in.gene_index;
            r_count <= i_in.count_value;
        end

        if (r_state == ST_IDLE && in_acc && i_in.mode == MODE_CLOSE) begin
            r_rem   <= {1'b0, r_mito_sum};
            r_quo   <= '0;
            r_step  <= '0;
            r_phase <= 1'b0;
        end else if (r_state == ST_DIV) begin
            if (w_last) begin
                // second pass divides the top count by the same total
                r_rem   <= {{(SUM_BITS-COUNT_BITS+1){1'b0}}, r_best_count};
                r_quo   <= '0;
                r_step  <= '0;
                r_phase <= 1'b1;
                if (r_phase) r_top_frac  <= w_frac;
                else         r_mito_frac <= w_frac;
            end else begin
                r_rem  <= w_ge ? w_diff[SUM_BITS:0] : w_trial;
                r_quo  <= w_quo_next;
                r_step <= r_step + 1'b1;
            end
        end

        if (r_state == ST_DONE && out_free) begin
            r_o_total    <= r_count_sum;
            r_o_tally    <= r_tally;
            r_o_mito     <= (r_mito_en && !w_zero) ? r_mito_frac : '0;
            r_o_top_gene <= r_max_en ? r_best_gene : '0;
            r_o_top_frac <= (r_max_en && !w_zero) ? r_top_frac : '0;
            r_o_zero     <= w_zero;
        end
    end

endmodule

`default_nettype wire
